@@ sv/tbi_pkg.sv @@
// ----------------------------------------------------------------------------
// tbi_pkg: shared types and constants of the turtle interpreter
// Fixed-point formats, symbol codes, register indexes, fault codes and the
// rounding / saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package tbi_pkg;

	// Position: signed pixels with 8 fraction bits. Heading: Q1.14.
	typedef logic signed [23:0] pos_t;
	typedef logic signed [15:0] head_t;

	// One saved turtle state on the branch stack
	typedef struct packed {
		pos_t  x;
		pos_t  y;
		head_t c;
		head_t s;
	} entry_t;

	// Stack commands from the core
	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} stk_ctrl_t;

	// Stack status back to the core
	typedef struct packed {
		logic empty;
		logic full;
	} stk_stat_t;

	typedef enum logic [1:0] {
		FAULT_NONE      = 2'd0,
		FAULT_OVERFLOW  = 2'd1,
		FAULT_UNDERFLOW = 2'd2,
		FAULT_UNKNOWN   = 2'd3
	} fault_t;

	// One result item
	typedef struct packed {
		logic   segment_valid;
		pos_t   x_from;
		pos_t   y_from;
		pos_t   x_to;
		pos_t   y_to;
		fault_t fault;
	} result_t;

	// Symbol codes
	localparam logic [7:0] SYM_FWD   = 8'h46;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_PUSH  = 8'h5B;
	localparam logic [7:0] SYM_POP   = 8'h5D;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd4;

	// Register reset values: 150 px step, 25 degree turn, start at (400, 600)
	localparam logic [19:0] STEP_RST    = 20'd38400;
	localparam head_t       COS_RST     = 16'sd14849;
	localparam head_t       SIN_RST     = 16'sd6924;
	localparam logic [19:0] START_X_RST = 20'd102400;
	localparam logic [19:0] START_Y_RST = 20'd153600;

	localparam head_t Q_ONE   = 16'sd16384;
	localparam head_t H_ZERO  = 16'sd0;
	localparam pos_t  POS_MAX = 24'sh7FFFFF;
	localparam pos_t  POS_MIN = -24'sh800000;
	localparam head_t H_MAX   = 16'sh7FFF;
	localparam head_t H_MIN   = -16'sh8000;

	// Divide a turn product sum by 2^14, round half up, saturate to 16 bits
	function automatic head_t rnd_sat16(input logic signed [32:0] v);
		logic signed [32:0] b;
		logic signed [18:0] q;
		b = v + 33'sd8192;
		q = b[32:14];
		if (q > 19'sd32767)
			return H_MAX;
		else if (q < -19'sd32768)
			return H_MIN;
		else
			return q[15:0];
	endfunction

	// Saturate a 25-bit coordinate sum to 24 bits
	function automatic pos_t sat24(input logic signed [24:0] v);
		if (v[24] != v[23])
			return v[24] ? POS_MIN : POS_MAX;
		else
			return v[23:0];
	endfunction

endpackage

@@ sv/tbi_sym_if.sv @@
// ----------------------------------------------------------------------------
// tbi_sym_if: symbol channel
// Valid/ready channel carrying one symbol byte and the restart flag per item.
// ----------------------------------------------------------------------------
interface tbi_sym_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       begin_req;

	modport source (output valid, output symbol, output begin_req, input ready);
	modport sink   (input valid, input symbol, input begin_req, output ready);
endinterface

@@ sv/tbi_seg_if.sv @@
// ----------------------------------------------------------------------------
// tbi_seg_if: segment channel
// Valid/ready channel carrying one result item: segment end points and fault.
// ----------------------------------------------------------------------------
interface tbi_seg_if;
	logic               valid;
	logic               ready;
	logic               segment_valid;
	logic signed [23:0] x_from;
	logic signed [23:0] y_from;
	logic signed [23:0] x_to;
	logic signed [23:0] y_to;
	logic [1:0]         fault;

	modport source (output valid, output segment_valid, output x_from, output y_from,
		output x_to, output y_to, output fault, input ready);
	modport sink   (input valid, input segment_valid, input x_from, input y_from,
		input x_to, input y_to, input fault, output ready);
endinterface

@@ sv/turtle_branch_interpreter_core.sv @@
// ----------------------------------------------------------------------------
// turtle_branch_interpreter_core: L-system turtle interpreter
// Interprets one symbol per item: move and emit a segment, turn, push or pop
// the turtle state, or report a fault, with saturating fixed-point arithmetic.
// ----------------------------------------------------------------------------
//  channel  direction  content
//  sym      in         symbol byte, begin_req
//  seg      out        segment_valid, x_from, y_from, x_to, y_to, fault
//  cfg      in         write enable, register index, 20-bit data
//
//  One item per cycle while sym is ready. The result of an item is registered
//  in the output buffer and offered on seg from there; the turn and move
//  multiplies are combinational, and a pop reads the top-of-stack registers.
//  A two-entry output buffer keeps sym ready while one result waits; ready
//  drops only while both entries are full.
//  Reset restores the registers and the turtle; the stack needs no clearing.
// ----------------------------------------------------------------------------
module turtle_branch_interpreter_core #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tbi_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tbi_pkg::CFG_DATA_W-1:0] cfg_data,
	tbi_sym_if.sink                        sym,
	tbi_seg_if.source                      seg
);
	import tbi_pkg::*;

	// Configuration registers
	logic [19:0] step_q;
	head_t       cos_ang_q;
	head_t       sin_ang_q;
	logic [19:0] start_x_q;
	logic [19:0] start_y_q;

	// Turtle state
	pos_t  x_q;
	pos_t  y_q;
	head_t hc_q;
	head_t hs_q;

	// Output buffer
	logic    out_vld_q;
	logic    skid_vld_q;
	result_t out_q;
	result_t skid_q;

	logic      accept;
	logic      restart;
	pos_t      cur_x;
	pos_t      cur_y;
	head_t     cur_c;
	head_t     cur_s;
	logic      eff_empty;
	logic      eff_full;
	stk_ctrl_t ctrl;
	entry_t    push_data;
	entry_t    stk_top;
	stk_stat_t stat;

	logic signed [31:0] p_cc;
	logic signed [31:0] p_ss;
	logic signed [31:0] p_sc;
	logic signed [31:0] p_cs;
	logic signed [32:0] nc_sum;
	logic signed [32:0] ns_sum;
	logic signed [20:0] step_s;
	logic signed [36:0] p_dx;
	logic signed [36:0] p_dy;
	logic signed [36:0] dx_b;
	logic signed [36:0] dy_b;
	logic signed [22:0] dx;
	logic signed [22:0] dy;
	logic signed [24:0] x_sum;
	logic signed [24:0] y_sum;
	pos_t               x_to;
	pos_t               y_to;

	logic    push_req;
	logic    pop_req;
	pos_t    nxt_x;
	pos_t    nxt_y;
	head_t   nxt_c;
	head_t   nxt_s;
	result_t res;

	assign accept  = sym.valid && sym.ready;
	assign restart = sym.begin_req;

	// Take the turtle as the restart leaves it
	always_comb begin
		cur_x     = restart ? pos_t'({4'b0, start_x_q}) : x_q;
		cur_y     = restart ? pos_t'({4'b0, start_y_q}) : y_q;
		cur_c     = restart ? Q_ONE : hc_q;
		cur_s     = restart ? H_ZERO : hs_q;
		eff_empty = restart || stat.empty;
		eff_full  = !restart && stat.full;
	end

	// Rotate the heading: minus turns use the negated sine
	always_comb begin
		p_cc = cur_c * cos_ang_q;
		p_ss = cur_s * sin_ang_q;
		p_sc = cur_s * cos_ang_q;
		p_cs = cur_c * sin_ang_q;
		if (sym.symbol == SYM_MINUS) begin
			nc_sum = {p_cc[31], p_cc} + {p_ss[31], p_ss};
			ns_sum = {p_sc[31], p_sc} - {p_cs[31], p_cs};
		end else begin
			nc_sum = {p_cc[31], p_cc} - {p_ss[31], p_ss};
			ns_sum = {p_sc[31], p_sc} + {p_cs[31], p_cs};
		end
	end

	// Move along the heading; y grows downward
	always_comb begin
		step_s = $signed({1'b0, step_q});
		p_dx   = step_s * cur_s;
		p_dy   = step_s * cur_c;
		dx_b   = p_dx + 37'sd8192;
		dy_b   = p_dy + 37'sd8192;
		dx     = dx_b[36:14];
		dy     = dy_b[36:14];
		x_sum  = {cur_x[23], cur_x} + {{2{dx[22]}}, dx};
		y_sum  = {cur_y[23], cur_y} - {{2{dy[22]}}, dy};
		x_to   = sat24(x_sum);
		y_to   = sat24(y_sum);
	end

	// Decode the symbol into the next state, stack command and result
	always_comb begin
		nxt_x    = cur_x;
		nxt_y    = cur_y;
		nxt_c    = cur_c;
		nxt_s    = cur_s;
		push_req = 1'b0;
		pop_req  = 1'b0;
		res      = '0;
		res.fault = FAULT_NONE;
		unique case (sym.symbol)
			SYM_FWD: begin
				nxt_x             = x_to;
				nxt_y             = y_to;
				res.segment_valid = 1'b1;
				res.x_from        = cur_x;
				res.y_from        = cur_y;
				res.x_to          = x_to;
				res.y_to          = y_to;
			end
			SYM_PLUS, SYM_MINUS: begin
				nxt_c = rnd_sat16(nc_sum);
				nxt_s = rnd_sat16(ns_sum);
			end
			SYM_PUSH: begin
				if (eff_full)
					res.fault = FAULT_OVERFLOW;
				else
					push_req = 1'b1;
			end
			SYM_POP: begin
				if (eff_empty) begin
					res.fault = FAULT_UNDERFLOW;
				end else begin
					pop_req = 1'b1;
					nxt_x   = stk_top.x;
					nxt_y   = stk_top.y;
					nxt_c   = stk_top.c;
					nxt_s   = stk_top.s;
				end
			end
			default: begin
				res.fault = FAULT_UNKNOWN;
			end
		endcase
	end

	always_comb begin
		ctrl.clear  = accept && restart;
		ctrl.push   = accept && push_req;
		ctrl.pop    = accept && pop_req;
		push_data.x = cur_x;
		push_data.y = cur_y;
		push_data.c = cur_c;
		push_data.s = cur_s;
	end

	tbi_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.push_data (push_data),
		.top       (stk_top),
		.stat      (stat)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_RST;
			cos_ang_q <= COS_RST;
			sin_ang_q <= SIN_RST;
			start_x_q <= START_X_RST;
			start_y_q <= START_Y_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STEP_LENGTH: step_q    <= cfg_data;
				REG_COS_ANGLE:   cos_ang_q <= cfg_data[15:0];
				REG_SIN_ANGLE:   sin_ang_q <= cfg_data[15:0];
				REG_START_X:     start_x_q <= cfg_data;
				REG_START_Y:     start_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the turtle on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= pos_t'({4'b0, START_X_RST});
			y_q  <= pos_t'({4'b0, START_Y_RST});
			hc_q <= Q_ONE;
			hs_q <= H_ZERO;
		end else if (accept) begin
			x_q  <= nxt_x;
			y_q  <= nxt_y;
			hc_q <= nxt_c;
			hs_q <= nxt_s;
		end
	end

	// Output buffer control: hold a second result while the first waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && seg.ready) begin
			if (skid_vld_q)
				skid_vld_q <= 1'b0;
			else if (!accept)
				out_vld_q <= 1'b0;
		end else if (accept) begin
			if (!out_vld_q)
				out_vld_q <= 1'b1;
			else
				skid_vld_q <= 1'b1;
		end
	end

	// Output buffer data
	always_ff @(posedge clk) begin
		if (out_vld_q && seg.ready) begin
			if (skid_vld_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= res;
		end else if (accept) begin
			if (!out_vld_q)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign sym.ready         = !skid_vld_q;
	assign seg.valid         = out_vld_q;
	assign seg.segment_valid = out_q.segment_valid;
	assign seg.x_from        = out_q.x_from;
	assign seg.y_from        = out_q.y_from;
	assign seg.x_to          = out_q.x_to;
	assign seg.y_to          = out_q.y_to;
	assign seg.fault         = out_q.fault;

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("second buffer entry held with the first empty");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_vld_q)
		else $error("accepted item left no result");

	a_segment_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.segment_valid |-> out_q.fault == FAULT_NONE)
		else $error("segment reported with a fault");

	a_no_segment_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_q.segment_valid |->
			out_q.x_from == '0 && out_q.y_from == '0 &&
			out_q.x_to == '0 && out_q.y_to == '0)
		else $error("coordinates set on a result without a segment");

endmodule

@@ sv/tbi_stack.sv @@
// ----------------------------------------------------------------------------
// tbi_stack: branch stack with a cached top entry
// The top entry and the one below it sit in registers so that a pop is
// served at once; deeper entries live in a memory whose registered read
// refills the entry below the top on every pop.
// ----------------------------------------------------------------------------
module tbi_stack #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tbi_pkg::stk_ctrl_t ctrl,
	input  tbi_pkg::entry_t    push_data,
	output tbi_pkg::entry_t    top,
	output tbi_pkg::stk_stat_t stat
);
	import tbi_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [FW-1:0] fill_q;
	logic [FW-1:0] base_fill;
	logic [FW-1:0] wr_idx;
	logic [FW-1:0] rd_idx;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	entry_t        mem [DEPTH];
	entry_t        top_q;
	entry_t        below_q;

	// A restart empties the stack before the symbol of the same item acts
	always_comb begin
		base_fill = ctrl.clear ? '0 : fill_q;
		wr_idx    = base_fill - FW'(1);
		rd_idx    = base_fill - FW'(3);
		wr_addr   = wr_idx[AW-1:0];
		rd_addr   = rd_idx[AW-1:0];
	end

	assign top        = top_q;
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == FW'(DEPTH));

	// Track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.push) begin
			fill_q <= base_fill + FW'(1);
		end else if (ctrl.pop) begin
			fill_q <= base_fill - FW'(1);
		end else if (ctrl.clear) begin
			fill_q <= '0;
		end
	end

	// Spill the old top into memory on push, refill from memory on pop
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (base_fill != '0)
				mem[wr_addr] <= top_q;
			top_q   <= push_data;
			below_q <= top_q;
		end else if (ctrl.pop) begin
			top_q   <= below_q;
			below_q <= mem[rd_addr];
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("stack fill beyond depth");

	a_push_inc: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> fill_q == $past(base_fill) + FW'(1))
		else $error("push did not raise the fill level");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> fill_q == $past(base_fill) - FW'(1))
		else $error("pop did not lower the fill level");

endmodule
